### design/pci_pkg.sv
package pci_pkg;

    // Default palette size
    localparam int PALETTE_DEPTH_DEF = 256;

    // Entry shown at the last index once a transparent palette is finalized
    localparam logic [23:0] BLUE_RGB = 24'h0000FF;

    // Command codes of an input item
    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // Sequencer states of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    // Input item
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] entry_index;
        logic       last_pixel;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0] pixel_index;
        logic       overflow_error;
        logic [8:0] color_count;
        logic [7:0] read_red;
        logic [7:0] read_green;
        logic [7:0] read_blue;
        logic       transparent_seen;
    } t_out_item;

    // Query token handed from cell to cell
    typedef struct packed {
        logic        valid;
        logic [23:0] rgb;
        logic [7:0]  entry;
        logic        hit;
        logic [7:0]  hit_idx;
        logic [23:0] rd;
    } t_tok;

endpackage

### design/pci_if.sv
interface pci_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/pci_cell.sv
module pci_cell
    import pci_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tok        i_tok,
    input  logic [8:0]  i_used,
    input  logic        i_wr_en,
    input  logic [7:0]  i_wr_idx,
    input  logic [23:0] i_wr_rgb,
    output t_tok        o_tok
);

    localparam logic [8:0] IDX9 = 9'(CELL_IDX);
    localparam logic [7:0] IDX8 = 8'(CELL_IDX);

    logic [23:0] r_color;
    t_tok        r_tok;
    t_tok        n_tok;

    // Store the color written to this entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == IDX8)) begin
            r_color <= i_wr_rgb;
        end
    end

    // Mark the first match and pick up the entry asked for
    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && (IDX9 < i_used) && (r_color == i_tok.rgb)) begin
            n_tok.hit     = 1'b1;
            n_tok.hit_idx = IDX8;
        end
        if (i_tok.entry == IDX8) begin
            n_tok.rd = r_color;
        end
    end

    // Advance the token to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.rgb     <= n_tok.rgb;
        r_tok.entry   <= n_tok.entry;
        r_tok.hit     <= n_tok.hit;
        r_tok.hit_idx <= n_tok.hit_idx;
        r_tok.rd      <= n_tok.rd;
    end

    assign o_tok = r_tok;

endmodule

### design/palette_color_indexer.sv
// Channel  Dir  Payload     Handshake
// i_pix    in   t_in_item   valid/ready, taken when both high
// o_res    out  t_out_item  valid/ready, taken when both high
//
// Items are taken one at a time. The query token walks the row of cells one
// entry per cycle, starting at the accepting edge. The tail register latches
// the end of the row, and the finish state folds it into the status and the
// output register, and the sequencer returns to idle to take the next item.
// The next item is taken even while the previous result waits to be taken.
// A new result is folded in only once the output register is free.
// Reset clears the counters, the flags and all valid bits, and holds the input
// not ready. Palette entries hold whatever they had until they are written.
// A stalled output holds its result.
module palette_color_indexer
    import pci_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pci_if.sink   i_pix,
    pci_if.source o_res
);

    localparam logic [8:0] DEPTH9   = 9'(PALETTE_DEPTH);
    localparam logic [8:0] LAST_IDX = 9'(PALETTE_DEPTH - 1);

    t_state      r_state;
    t_state      n_state;
    t_in_item    r_item;
    t_tok        r_tail;
    logic [8:0]  r_used;
    logic        r_trans;
    logic        r_err;
    logic        r_fin;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [8:0]  n_used;
    logic        n_trans;
    logic        n_err;
    logic        n_fin;
    logic [7:0]  w_pix;
    logic [23:0] w_rd;
    logic        w_wr_req;
    logic [8:0]  w_limit;
    logic        w_in_ready;
    logic        w_fin_fire;
    logic        w_accept;
    logic        w_out_free;
    t_tok        w_tok [0:PALETTE_DEPTH];

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_accept   = i_pix.valid && w_in_ready;

    // Build the query token from the incoming item
    always_comb begin
        w_tok[0].valid   = w_accept;
        w_tok[0].rgb     = {i_pix.data.red, i_pix.data.green, i_pix.data.blue};
        w_tok[0].entry   = i_pix.data.entry_index;
        w_tok[0].hit     = 1'b0;
        w_tok[0].hit_idx = 8'd0;
        w_tok[0].rd      = 24'd0;
    end

    // Row of palette cells
    for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
        pci_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[g]),
            .i_used   (r_used),
            .i_wr_en  (w_fin_fire && w_wr_req),
            .i_wr_idx (r_used[7:0]),
            .i_wr_rgb (r_tail.rgb),
            .o_tok    (w_tok[g+1])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_WALK;
            ST_WALK:   if (w_tok[PALETTE_DEPTH].valid) n_state = ST_FINISH;
            ST_FINISH: if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_fin_fire = 1'b0;
        case (r_state)
            ST_IDLE:   w_in_ready = i_rst_n;
            ST_WALK:   ;
            ST_FINISH: w_fin_fire = w_out_free;
            default:   ;
        endcase
    end

    assign i_pix.ready = w_in_ready;

    // Fold the walked token into the palette status
    always_comb begin
        n_used   = r_used;
        n_trans  = r_trans;
        n_err    = r_err;
        n_fin    = r_fin;
        w_pix    = 8'd0;
        w_rd     = 24'd0;
        w_wr_req = 1'b0;
        w_limit  = r_trans ? LAST_IDX : DEPTH9;
        case (r_item.command)
            CMD_PIXEL: begin
                if (r_item.alpha == 8'd0) begin
                    n_trans = 1'b1;
                    w_pix   = LAST_IDX[7:0];
                end else if (r_tail.hit) begin
                    w_pix = r_tail.hit_idx;
                end else if (r_used >= w_limit) begin
                    n_err = 1'b1;
                end else begin
                    w_wr_req = 1'b1;
                    w_pix    = r_used[7:0];
                    n_used   = r_used + 9'd1;
                end
                if (r_item.last_pixel) begin
                    n_fin = 1'b1;
                end
            end
            CMD_READ: begin
                if ({1'b0, r_item.entry_index} >= DEPTH9) begin
                    w_rd = 24'd0;
                end else if (r_fin && r_trans && ({1'b0, r_item.entry_index} == LAST_IDX)) begin
                    w_rd = BLUE_RGB;
                end else if ({1'b0, r_item.entry_index} < r_used) begin
                    w_rd = r_tail.rd;
                end
            end
            CMD_CLEAR: begin
                n_used  = 9'd0;
                n_trans = 1'b0;
                n_err   = 1'b0;
                n_fin   = 1'b0;
            end
            default: ;
        endcase
    end

    // Hold the item and the token tail
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_pix.data;
        end
        if ((r_state == ST_WALK) && w_tok[PALETTE_DEPTH].valid) begin
            r_tail <= w_tok[PALETTE_DEPTH];
        end
    end

    // Sequencer and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= 9'd0;
            r_trans <= 1'b0;
            r_err   <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin_fire) begin
                r_used  <= n_used;
                r_trans <= n_trans;
                r_err   <= n_err;
                r_fin   <= n_fin;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_fin_fire) begin
            r_out.pixel_index      <= w_pix;
            r_out.overflow_error   <= n_err;
            r_out.color_count      <= (n_fin && n_trans) ? DEPTH9 : n_used;
            r_out.read_red         <= w_rd[23:16];
            r_out.read_green       <= w_rd[15:8];
            r_out.read_blue        <= w_rd[7:0];
            r_out.transparent_seen <= n_trans;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

### design/pci_checker.sv
module pci_checker
    import pci_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // One item at a time: no item taken in the cycle after one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second item taken while one is in work");

    // Count never exceeds the palette size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.color_count <= DEPTH9))
        else $error("color count above palette size");

    // Read-back data comes only with a zero pixel index
    a_read_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && ((i_out_data.read_red != 8'd0) || (i_out_data.read_green != 8'd0)
            || (i_out_data.read_blue != 8'd0))) |-> (i_out_data.pixel_index == 8'd0))
        else $error("read data with nonzero pixel index");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

endmodule

bind palette_color_indexer pci_checker #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
) u_pci_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

### verif/palette_color_indexer_tb.sv
`timescale 1ns / 1ps

module palette_color_indexer_tb;
    import pci_pkg::*;

    localparam int          CLK_PERIOD  = 12;
    localparam int          RESET_CYCLES = 12;
    localparam int          ITEM_TARGET = 1950;
    localparam int          QUIET_TAIL  = 150;
    localparam int          ITEM_CYCLES = PALETTE_DEPTH_DEF + 2;
    localparam int          DRAIN_CYCLES = 2 * ITEM_CYCLES + 16;
    localparam int          CYCLE_LIMIT = 2_500_000;
    localparam int          FILL_COLORS = PALETTE_DEPTH_DEF + 2;
    localparam logic [1:0]  CMD_UNDEF   = 2'd3;

    // Palette predictor plus the queue of results it owes the output side
    class palette_scoreboard;
        logic [23:0] pal_colors [PALETTE_DEPTH_DEF];
        logic [8:0]  pal_used;
        bit          seen_transparent;
        bit          seen_overflow;
        bit          is_finalized;
        t_out_item   pending_results [$];
        int          error_count;

        function new();
            clear_palette();
            error_count = 0;
        endfunction

        function void clear_palette();
            pal_used         = '0;
            seen_transparent = 1'b0;
            seen_overflow    = 1'b0;
            is_finalized     = 1'b0;
        endfunction

        // Alpha 0 gets the last index; else match RGB, lowest entry first; append on a miss unless full
        function logic [7:0] assign_index(logic [23:0] rgb, logic [7:0] alpha);
            int limit;
            if (alpha == 8'h00) begin
                seen_transparent = 1'b1;
                return 8'(PALETTE_DEPTH_DEF - 1);
            end
            for (int i = 0; i < int'(pal_used); i++) begin
                if (pal_colors[i] == rgb)
                    return 8'(i);
            end
            limit = seen_transparent ? PALETTE_DEPTH_DEF - 1 : PALETTE_DEPTH_DEF;
            if (int'(pal_used) >= limit) begin
                seen_overflow = 1'b1;
                return 8'h00;
            end
            pal_colors[pal_used] = rgb;
            pal_used++;
            return 8'(pal_used - 1);
        endfunction

        // Entries past the used count read black; the finalized view shows blue last
        function logic [23:0] entry_color(logic [7:0] entry);
            if (int'(entry) >= PALETTE_DEPTH_DEF)
                return '0;
            if (is_finalized && seen_transparent && int'(entry) == PALETTE_DEPTH_DEF - 1)
                return BLUE_RGB;
            if (9'(entry) < pal_used)
                return pal_colors[entry];
            return '0;
        endfunction

        function void note_accepted_item(t_in_item it);
            t_out_item exp_r;
            exp_r = '0;
            case (it.command)
                CMD_PIXEL: begin
                    exp_r.pixel_index = assign_index({it.red, it.green, it.blue}, it.alpha);
                    if (it.last_pixel)
                        is_finalized = 1'b1;
                end
                CMD_READ: begin
                    {exp_r.read_red, exp_r.read_green, exp_r.read_blue} =
                        entry_color(it.entry_index);
                end
                CMD_CLEAR: begin
                    clear_palette();
                end
                default: begin
                end
            endcase
            exp_r.overflow_error   = seen_overflow;
            exp_r.color_count      = (is_finalized && seen_transparent) ?
                                     9'(PALETTE_DEPTH_DEF) : pal_used;
            exp_r.transparent_seen = seen_transparent;
            pending_results.push_back(exp_r);
        endfunction

        function void compare_field(string name, logic [8:0] exp_v, logic [8:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch: expected %0d, got %0d",
                         $time, name, exp_v, act_v);
                error_count++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_r;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %p", $time, got);
                error_count++;
                return;
            end
            exp_r = pending_results.pop_front();
            compare_field("pixel_index", 9'(exp_r.pixel_index), 9'(got.pixel_index));
            compare_field("overflow_error", 9'(exp_r.overflow_error),
                          9'(got.overflow_error));
            compare_field("color_count", exp_r.color_count, got.color_count);
            compare_field("read_red", 9'(exp_r.read_red), 9'(got.read_red));
            compare_field("read_green", 9'(exp_r.read_green), 9'(got.read_green));
            compare_field("read_blue", 9'(exp_r.read_blue), 9'(got.read_blue));
            compare_field("transparent_seen", 9'(exp_r.transparent_seen),
                          9'(got.transparent_seen));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   idling_on;
    int   items_sent;
    int   cycle_count = 0;

    palette_scoreboard sb;

    pci_if #(.T(t_in_item))  pix_if ();
    pci_if #(.T(t_out_item)) res_if ();

    palette_color_indexer u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_if.sink),
        .o_res   (res_if.source)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Give up once the run is far past its slowest legal length
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_in_item pixel_item(logic [23:0] rgb, logic [7:0] alpha, logic last);
        t_in_item it;
        it.command     = CMD_PIXEL;
        {it.red, it.green, it.blue} = rgb;
        it.alpha       = alpha;
        it.entry_index = 8'($urandom);
        it.last_pixel  = last;
        return it;
    endfunction

    // Non-pixel item with junk in the fields it does not use
    function automatic t_in_item control_item(logic [1:0] cmd, logic [7:0] entry);
        t_in_item it;
        it.command     = cmd;
        {it.red, it.green, it.blue} = 24'($urandom);
        it.alpha       = 8'($urandom);
        it.entry_index = entry;
        it.last_pixel  = 1'($urandom);
        return it;
    endfunction

    function automatic logic [23:0] fill_color(logic [23:0] base, int k);
        return base ^ {k[7:0], 7'h00, k[8], k[7:0]};
    endfunction

    // While idling is on, sometimes hold off for a random burst, then present the item until it is taken
    task automatic send_item(t_in_item it);
        if (idling_on && $urandom_range(0, 2) == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.data  <= it;
        @(posedge clk);
        while (!pix_if.ready) @(posedge clk);
        sb.note_accepted_item(it);
        items_sent++;
    endtask

    task automatic run_directed();
        send_item(control_item(CMD_CLEAR, 8'h00));
        send_item(control_item(CMD_READ, 8'h00));
        send_item(pixel_item(24'h000000, 8'hFF, 1'b0));
        send_item(pixel_item(24'hFFFFFF, 8'h01, 1'b0));
        send_item(pixel_item(24'h000000, 8'h80, 1'b0));
        send_item(pixel_item(24'hFF00FF, 8'hFF, 1'b0));
        send_item(control_item(CMD_READ, 8'h01));
        send_item(control_item(CMD_READ, 8'hFF));
        send_item(control_item(CMD_UNDEF, 8'h02));
        send_item(control_item(CMD_READ, 8'h02));
        // transparent pixel, then finalize
        send_item(pixel_item(24'hFFFFFF, 8'h00, 1'b0));
        send_item(pixel_item(24'h123456, 8'hFE, 1'b1));
        send_item(control_item(CMD_READ, 8'hFF));
        send_item(control_item(CMD_READ, 8'hC8));
        send_item(control_item(CMD_READ, 8'h03));
        // pixels after finalize still append; last again keeps the flag
        send_item(pixel_item(24'hAABBCC, 8'h7F, 1'b0));
        send_item(pixel_item(24'h00FF00, 8'h00, 1'b1));
        send_item(control_item(CMD_READ, 8'h04));
        send_item(control_item(CMD_CLEAR, 8'hFF));
        send_item(control_item(CMD_READ, 8'hFF));
        send_item(pixel_item(24'h0000FF, 8'hFF, 1'b1));
        send_item(control_item(CMD_READ, 8'h00));
    endtask

    // Fill past capacity; trans_at picks where the transparent pixel lands
    task automatic fill_palette(int trans_at);
        logic [23:0] base;
        base = 24'($urandom);
        send_item(control_item(CMD_CLEAR, 8'($urandom)));
        for (int k = 0; k < FILL_COLORS; k++) begin
            if (k == trans_at)
                send_item(pixel_item(24'($urandom), 8'h00, 1'b0));
            send_item(pixel_item(fill_color(base, k), 8'($urandom_range(1, 255)), 1'b0));
            if (k % 40 == 39) begin
                send_item(pixel_item(fill_color(base, $urandom_range(0, k)),
                                     8'($urandom_range(1, 255)), 1'b0));
                send_item(control_item(CMD_READ, 8'($urandom_range(0, k))));
            end
        end
        if (trans_at >= FILL_COLORS) begin
            // already past the limit: a transparent pixel, then a new color
            send_item(pixel_item(24'($urandom), 8'h00, 1'b0));
            send_item(pixel_item(~base, 8'($urandom_range(1, 255)), 1'b0));
        end
        send_item(control_item(CMD_READ, 8'hFF));
        send_item(pixel_item(fill_color(base, PALETTE_DEPTH_DEF - 1),
                             8'($urandom_range(1, 255)), 1'b1));
        send_item(control_item(CMD_READ, 8'hFF));
        send_item(control_item(CMD_READ, 8'hFE));
        send_item(pixel_item(~base, 8'hFF, 1'b0));
    endtask

    // Short image over a small color pool, reads and odd items mixed in
    task automatic send_image();
        logic [23:0] pool [24];
        int          pool_n;
        int          len;
        int          pick;
        if ($urandom_range(0, 7) != 0)
            send_item(control_item(CMD_CLEAR, 8'($urandom)));
        pool_n = $urandom_range(1, 24);
        for (int i = 0; i < pool_n; i++)
            pool[i] = 24'($urandom);
        len = $urandom_range(4, 40);
        for (int p = 0; p < len; p++) begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                send_item(control_item(CMD_READ, 8'($urandom_range(0, pool_n + 1))));
            else if (pick == 1)
                send_item(pixel_item(24'($urandom), 8'h00, 1'b0));
            else if (pick == 2)
                send_item(control_item(CMD_UNDEF, 8'($urandom)));
            else
                send_item(pixel_item(pool[$urandom_range(0, pool_n - 1)],
                                     8'($urandom_range(1, 255)), 1'b0));
        end
        send_item(pixel_item(pool[$urandom_range(0, pool_n - 1)],
                             8'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 255)),
                             1'b1));
        repeat ($urandom_range(0, 3)) begin
            send_item(control_item(CMD_READ, $urandom_range(0, 3) == 0 ?
                                   8'hFF : 8'($urandom_range(0, pool_n))));
        end
    endtask

    // Fully random items, any command
    task automatic send_noise();
        t_in_item it;
        repeat ($urandom_range(3, 12)) begin
            it.command     = 2'($urandom_range(0, 3));
            {it.red, it.green, it.blue} = 24'($urandom);
            it.alpha       = $urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom);
            it.entry_index = 8'($urandom);
            it.last_pixel  = 1'($urandom);
            send_item(it);
        end
    endtask

    task automatic run_random();
        int image_no;
        image_no = 0;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - QUIET_TAIL)
                idling_on = 1'b0;
            if (image_no == 4)
                fill_palette(0);
            else if (image_no == 14)
                fill_palette(FILL_COLORS);
            else if (image_no == 24)
                fill_palette(100);
            else if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_image();
            image_no++;
        end
    endtask

    // Take results with random stall bursts and check each one
    initial begin
        int stall_left;
        stall_left   = 0;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.data);
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 15) == 0) begin
                stall_left   = $urandom_range(0, 6);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        sb           = new();
        rst_n        = 1'b0;
        idling_on    = 1'b1;
        items_sent   = 0;
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random();
        pix_if.valid <= 1'b0;
        // drain outstanding results, then watch for strays
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count == 0 && sb.pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
